### hw/rtl/bgr_pkg.sv
// Shared types and constants for the button gesture recognizer.
`timescale 1ns / 1ps
package bgr_pkg;

  // Input command codes (carried on in_tuser)
  typedef enum logic [1:0] {
    CMD_PRESS   = 2'd0,
    CMD_RELEASE = 2'd1,
    CMD_MOVE    = 2'd2,
    CMD_TICK    = 2'd3
  } cmd_code_t;

  // Event kinds (carried on out_tuser)
  typedef enum logic [2:0] {
    EV_DOWN   = 3'd0,
    EV_DRAG   = 3'd1,
    EV_UP     = 3'd2,
    EV_CLICK  = 3'd3,
    EV_DCLICK = 3'd4,
    EV_MOVE   = 3'd5
  } ev_kind_t;

  // Per-button phase; code 3 never arises and behaves as idle
  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_DRAG  = 2'd1,
    PH_CLICK = 2'd2
  } phase_t;

  // Configuration register indexes
  typedef enum logic [1:0] {
    CFG_DCLICK_TICKS = 2'd0,
    CFG_MAX_MOVE     = 2'd1,
    CFG_DRAG_LIMIT   = 2'd2
  } cfg_idx_t;

  localparam logic [15:0] DCLICK_TICKS_RST = 16'd200;
  localparam logic [15:0] MAX_MOVE_RST     = 16'd5;
  localparam logic [15:0] DRAG_LIMIT_RST   = 16'd8;
  localparam int          CURSOR_RST       = 100;

  // Datapath operations issued by the controller
  typedef enum logic [2:0] {
    OP_NONE,
    OP_BUTTON,
    OP_TICK_EV,
    OP_STEP,
    OP_FLUSH
  } dp_op_t;

  typedef struct packed {
    logic   capture;
    dp_op_t op;
  } dp_cmd_t;

  typedef struct packed {
    logic out_free;
    logic pend_valid;
  } dp_status_t;

  // One result item, without the last marker
  typedef struct packed {
    ev_kind_t    kind;
    logic [3:0]  button;
    logic [15:0] cur_x;
    logic [15:0] cur_y;
    logic [15:0] prev_x;
    logic [15:0] prev_y;
    logic [15:0] drag_total;
  } evt_t;

endpackage

### hw/rtl/bgr_ctrl.sv
// Controller state machine: accepts items and walks the button records.
`timescale 1ns / 1ps
module bgr_ctrl #(
  parameter int NUM_BUTTONS = 16,
  parameter int IDX_W       = 4
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [1:0]           in_cmd,
  input  logic [3:0]           in_button,
  input  bgr_pkg::dp_status_t  status,
  output bgr_pkg::dp_cmd_t     cmd,
  output logic [IDX_W-1:0]     idx
);
  import bgr_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_BTN,
    S_TICK,
    S_WALK,
    S_FLUSH
  } state_t;

  state_t           state_r;
  logic [IDX_W-1:0] idx_r;
  logic             accept;
  logic             btn_ok;

  assign in_tready = (state_r == S_IDLE);
  assign accept    = in_tvalid && in_tready;
  assign btn_ok    = int'(in_button) < NUM_BUTTONS;
  assign idx       = idx_r;

  always_comb begin
    cmd.capture = accept;
    cmd.op      = OP_NONE;
    unique case (state_r)
      S_BTN:   if (status.out_free) cmd.op = OP_BUTTON;
      S_TICK:  if (status.out_free) cmd.op = OP_TICK_EV;
      S_WALK:  if (status.out_free) cmd.op = OP_STEP;
      S_FLUSH: if (status.out_free && status.pend_valid) cmd.op = OP_FLUSH;
      default: cmd.op = OP_NONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      idx_r   <= '0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          idx_r <= '0;
          if (accept) begin
            priority case (in_cmd)
              CMD_PRESS, CMD_RELEASE: state_r <= btn_ok ? S_BTN : S_IDLE;
              CMD_MOVE:               state_r <= S_WALK;
              default:                state_r <= S_TICK;
            endcase
          end
        end
        S_BTN:  if (status.out_free) state_r <= S_FLUSH;
        S_TICK: if (status.out_free) state_r <= S_WALK;
        S_WALK: begin
          if (status.out_free) begin
            if (idx_r == IDX_W'(NUM_BUTTONS - 1)) begin
              state_r <= S_FLUSH;
            end else begin
              idx_r <= idx_r + IDX_W'(1);
            end
          end
        end
        S_FLUSH: begin
          if (!status.pend_valid) begin
            state_r <= S_IDLE;
          end else if (status.out_free) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

### hw/rtl/bgr_dpath.sv
// Datapath: cursor, button records, configuration and result registers.
`timescale 1ns / 1ps
module bgr_dpath #(
  parameter int NUM_BUTTONS = 16,
  parameter int COORD_BITS  = 16,
  parameter int IDX_W       = 4
) (
  input  logic                clk,
  input  logic                rst_n,
  input  bgr_pkg::dp_cmd_t    cmd,
  input  logic [IDX_W-1:0]    idx,
  output bgr_pkg::dp_status_t status,
  input  logic [1:0]          in_cmd,
  input  logic [3:0]          in_button,
  input  logic signed [15:0]  in_pos_x,
  input  logic signed [15:0]  in_pos_y,
  input  logic [15:0]         in_elapsed,
  input  logic                cfg_wr,
  input  logic [1:0]          cfg_index,
  input  logic [15:0]         cfg_data,
  input  logic                out_tready,
  output logic                out_valid,
  output bgr_pkg::evt_t       out_evt,
  output logic                out_last
);
  import bgr_pkg::*;

  localparam int AD_W  = COORD_BITS + 1;
  localparam int SUM_W = ((AD_W > 16) ? AD_W : 16) + 2;

  typedef logic signed [COORD_BITS-1:0] coord_t;

  function automatic logic [AD_W-1:0] abs_diff(coord_t a, coord_t b);
    logic signed [AD_W-1:0] d;
    d = AD_W'(a) - AD_W'(b);
    return d[AD_W-1] ? AD_W'(-d) : AD_W'(d);
  endfunction

  function automatic logic [15:0] to16(coord_t v);
    return 16'(v);
  endfunction

  // configuration
  logic [15:0] dclick_ticks_r, max_move_r, drag_limit_r;

  // latched item and cursor
  cmd_code_t   cmd_r;
  logic [3:0]  btn_r;
  logic [15:0] el_r;
  coord_t      cursor_x_r, cursor_y_r;

  // button records
  phase_t      phase_r  [NUM_BUTTONS];
  logic [15:0] timer_r  [NUM_BUTTONS];
  coord_t      pos_x_r  [NUM_BUTTONS];
  coord_t      pos_y_r  [NUM_BUTTONS];
  coord_t      prev_x_r [NUM_BUTTONS];
  coord_t      prev_y_r [NUM_BUTTONS];
  logic [15:0] drag_r   [NUM_BUTTONS];

  // result staging: pend holds the newest event until it is known to be last
  evt_t pend_r;
  logic pend_valid_r;
  evt_t out_r;
  logic out_valid_r;
  logic out_last_r;

  logic [IDX_W-1:0] sel;
  phase_t      ph, ph_nxt;
  logic [15:0] tmr, tmr_nxt, drg, drg_nxt;
  coord_t      px, py, qx, qy, px_nxt, py_nxt, qx_nxt, qy_nxt;
  logic        rec_we, emit;
  evt_t        ev;
  logic [16:0]      tsum;
  logic [SUM_W-1:0] dsum;

  assign sel = (cmd.op == OP_BUTTON) ? IDX_W'(btn_r) : idx;
  assign ph  = phase_r[sel];
  assign tmr = timer_r[sel];
  assign drg = drag_r[sel];
  assign px  = pos_x_r[sel];
  assign py  = pos_y_r[sel];
  assign qx  = prev_x_r[sel];
  assign qy  = prev_y_r[sel];

  assign tsum = {1'b0, tmr} + {1'b0, el_r};
  assign dsum = SUM_W'(drg) + SUM_W'(abs_diff(px, cursor_x_r))
              + SUM_W'(abs_diff(py, cursor_y_r));

  always_comb begin
    ph_nxt  = ph;
    tmr_nxt = tmr;
    drg_nxt = drg;
    px_nxt  = px;
    py_nxt  = py;
    qx_nxt  = qx;
    qy_nxt  = qy;
    rec_we  = 1'b0;
    emit    = 1'b0;
    ev.kind = EV_MOVE;
    unique case (cmd.op)
      OP_BUTTON: begin
        rec_we = 1'b1;
        emit   = 1'b1;
        px_nxt = cursor_x_r;
        py_nxt = cursor_y_r;
        if (cmd_r == CMD_PRESS) begin
          if (ph == PH_CLICK && tmr < dclick_ticks_r) begin
            ev.kind = EV_DCLICK;
            ph_nxt  = PH_IDLE;
          end else begin
            qx_nxt  = cursor_x_r;
            qy_nxt  = cursor_y_r;
            drg_nxt = '0;
            ev.kind = EV_DOWN;
            ph_nxt  = PH_DRAG;
          end
        end else begin
          ev.kind = EV_UP;
          if (ph == PH_DRAG && drg < drag_limit_r) begin
            tmr_nxt = '0;
            ph_nxt  = PH_CLICK;
          end else begin
            ph_nxt  = PH_IDLE;
          end
        end
      end
      OP_TICK_EV: begin
        emit    = 1'b1;
        ev.kind = EV_MOVE;
      end
      OP_STEP: begin
        if (cmd_r == CMD_MOVE) begin
          if (ph == PH_DRAG) begin
            rec_we  = 1'b1;
            emit    = 1'b1;
            ev.kind = EV_DRAG;
            drg_nxt = (dsum > SUM_W'(16'hFFFF)) ? 16'hFFFF : dsum[15:0];
            qx_nxt  = px;
            qy_nxt  = py;
            px_nxt  = cursor_x_r;
            py_nxt  = cursor_y_r;
          end
        end else begin
          if (ph == PH_CLICK) begin
            rec_we  = 1'b1;
            tmr_nxt = tsum[16] ? 16'hFFFF : tsum[15:0];
            if (tmr_nxt >= dclick_ticks_r
                || SUM_W'(abs_diff(cursor_x_r, qx)) > SUM_W'(max_move_r)
                || SUM_W'(abs_diff(cursor_y_r, qy)) > SUM_W'(max_move_r)) begin
              emit    = 1'b1;
              ev.kind = EV_CLICK;
              ph_nxt  = PH_IDLE;
            end
          end
        end
      end
      default: begin
        emit = 1'b0;
      end
    endcase

    if (cmd.op == OP_TICK_EV) begin
      ev.button     = '0;
      ev.cur_x      = to16(cursor_x_r);
      ev.cur_y      = to16(cursor_y_r);
      ev.prev_x     = to16(cursor_x_r);
      ev.prev_y     = to16(cursor_y_r);
      ev.drag_total = '0;
    end else begin
      ev.button     = 4'(sel);
      ev.cur_x      = to16(px_nxt);
      ev.cur_y      = to16(py_nxt);
      ev.prev_x     = to16(qx_nxt);
      ev.prev_y     = to16(qy_nxt);
      ev.drag_total = drg_nxt;
    end
  end

  // configuration, cursor and button records
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dclick_ticks_r <= DCLICK_TICKS_RST;
      max_move_r     <= MAX_MOVE_RST;
      drag_limit_r   <= DRAG_LIMIT_RST;
      cursor_x_r     <= COORD_BITS'(CURSOR_RST);
      cursor_y_r     <= COORD_BITS'(CURSOR_RST);
      for (int b = 0; b < NUM_BUTTONS; b++) begin
        phase_r[b]  <= PH_IDLE;
        timer_r[b]  <= '0;
        pos_x_r[b]  <= '0;
        pos_y_r[b]  <= '0;
        prev_x_r[b] <= '0;
        prev_y_r[b] <= '0;
        drag_r[b]   <= '0;
      end
    end else begin
      if (cfg_wr) begin
        priority case (cfg_index)
          CFG_DCLICK_TICKS: dclick_ticks_r <= cfg_data;
          CFG_MAX_MOVE:     max_move_r     <= cfg_data;
          CFG_DRAG_LIMIT:   drag_limit_r   <= cfg_data;
          default: ;
        endcase
      end
      if (cmd.capture && in_cmd == CMD_MOVE) begin
        cursor_x_r <= COORD_BITS'(in_pos_x);
        cursor_y_r <= COORD_BITS'(in_pos_y);
      end
      if (rec_we) begin
        phase_r[sel]  <= ph_nxt;
        timer_r[sel]  <= tmr_nxt;
        pos_x_r[sel]  <= px_nxt;
        pos_y_r[sel]  <= py_nxt;
        prev_x_r[sel] <= qx_nxt;
        prev_y_r[sel] <= qy_nxt;
        drag_r[sel]   <= drg_nxt;
      end
    end
  end

  // latched item fields
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      cmd_r <= cmd_code_t'(in_cmd);
      btn_r <= in_button;
      el_r  <= in_elapsed;
    end
  end

  // staging control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cmd.op == OP_FLUSH) begin
        out_valid_r  <= 1'b1;
        pend_valid_r <= 1'b0;
      end else if (emit) begin
        if (pend_valid_r) begin
          out_valid_r <= 1'b1;
        end else if (out_tready) begin
          out_valid_r <= 1'b0;
        end
        pend_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // staging payload
  always_ff @(posedge clk) begin
    if (cmd.op == OP_FLUSH) begin
      out_r      <= pend_r;
      out_last_r <= 1'b1;
    end else if (emit) begin
      if (pend_valid_r) begin
        out_r      <= pend_r;
        out_last_r <= 1'b0;
      end
      pend_r <= ev;
    end
  end

  assign status.out_free   = !out_valid_r || out_tready;
  assign status.pend_valid = pend_valid_r;
  assign out_valid = out_valid_r;
  assign out_evt   = out_r;
  assign out_last  = out_last_r;

endmodule

### hw/rtl/button_gesture_recognizer.sv
// Top level of the button gesture recognizer: ports, controller and datapath.
//
// Usage:
//   in_*  : one beat per input item. in_tuser carries the command (press,
//           release, cursor move, tick); in_tdata the button, position and
//           elapsed ticks. One item is in work at a time.
//   out_* : one beat per event. out_tuser carries the event kind, out_tdata
//           the button, current/previous position and drag total; out_tlast
//           marks the final event that an input item produced.
//   cfg_* : register writes (index, 16-bit data), always ready; write only
//           while the block is idle.
// Item handling: a press or release updates its own button record; a cursor
//   move walks over all button records, one record per cycle while the output
//   can move, and a tick emits a move event before the same walk.
// The newest event waits in a pending register until it is known whether it
//   is last; it moves to the output when the next event arrives or at the flush.
// A stalled receiver freezes the walk; no event is dropped or repeated.
// Reset clears the controller, the staging valid flags, the cursor (100, 100),
//   all button records and loads the register reset values.
`timescale 1ns / 1ps
module button_gesture_recognizer #(
  parameter int NUM_BUTTONS = 16,
  parameter int COORD_BITS  = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  // slave side
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [1:0]  in_tuser,   // cmd
  input  logic [55:0] in_tdata,   // button, pos_x, pos_y, elapsed_ticks, pad
  // master side
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [2:0]  out_tuser,  // event_kind
  output logic [87:0] out_tdata,  // event_button, cur_x, cur_y, prev_x, prev_y,
                                  // drag_total, pad
  output logic        out_tlast,  // last_event
  // configuration
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);
  import bgr_pkg::*;

  localparam int IDX_W = (NUM_BUTTONS > 1) ? $clog2(NUM_BUTTONS) : 1;

  dp_cmd_t          dp_cmd;
  dp_status_t       dp_status;
  logic [IDX_W-1:0] walk_idx;
  evt_t             out_evt;

  assign cfg_ready = 1'b1;

  // Sequence each item: capture, button update or record walk, final flush.
  bgr_ctrl #(
    .NUM_BUTTONS (NUM_BUTTONS),
    .IDX_W       (IDX_W)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_cmd    (in_tuser),
    .in_button (in_tdata[3:0]),
    .status    (dp_status),
    .cmd       (dp_cmd),
    .idx       (walk_idx)
  );

  // Hold state, compute events, and stage one beat behind the newest event.
  bgr_dpath #(
    .NUM_BUTTONS (NUM_BUTTONS),
    .COORD_BITS  (COORD_BITS),
    .IDX_W       (IDX_W)
  ) u_dpath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (dp_cmd),
    .idx        (walk_idx),
    .status     (dp_status),
    .in_cmd     (in_tuser),
    .in_button  (in_tdata[3:0]),
    .in_pos_x   (in_tdata[19:4]),
    .in_pos_y   (in_tdata[35:20]),
    .in_elapsed (in_tdata[51:36]),
    .cfg_wr     (cfg_valid && cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .out_tready (out_tready),
    .out_valid  (out_tvalid),
    .out_evt    (out_evt),
    .out_last   (out_tlast)
  );

  assign out_tuser = out_evt.kind;
  assign out_tdata = {4'b0, out_evt.drag_total, out_evt.prev_y, out_evt.prev_x,
                      out_evt.cur_y, out_evt.cur_x, out_evt.button};

`ifndef SYNTHESIS
  // An idle block must have no event left in staging.
  a_idle_no_pend: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> !dp_status.pend_valid)
    else $error("event left in staging while idle");

  // Datapath operations are only issued when the output register can move.
  a_op_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
    dp_cmd.op != OP_NONE |-> dp_status.out_free)
    else $error("datapath operation issued without output room");

  // A move or tick keeps the block busy for its record walk.
  a_walk_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && (in_tuser == CMD_MOVE || in_tuser == CMD_TICK))
      |=> !in_tready)
    else $error("new item accepted during record walk");
`endif

endmodule
